// ----- hdl/tecs_pkg.sv -----
// Shared constants, codes, decode function and control structs for the tiny 8-bit core.
// No dependencies; the controller, datapath, core and testbench import this package.
package tecs_pkg;

	// code store depth (16..256) and its address width
	localparam int         CODE_DEPTH = 256;
	localparam int         CODE_AW    = $clog2(CODE_DEPTH);
	localparam logic [8:0] CODE_LIMIT = 9'(CODE_DEPTH);

	localparam int DATA_DEPTH = 256;
	localparam int DATA_AW    = $clog2(DATA_DEPTH);
	localparam int NUM_REGS   = 4;

	// commands
	localparam logic [1:0] CMD_WCODE = 2'd0;
	localparam logic [1:0] CMD_WDATA = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_EXEC  = 2'd3;

	// events
	localparam logic [2:0] EV_DONE   = 3'd0;
	localparam logic [2:0] EV_PRINT  = 3'd1;
	localparam logic [2:0] EV_RETURN = 3'd2;
	localparam logic [2:0] EV_FAULT  = 3'd3;
	localparam logic [2:0] EV_HALTED = 3'd4;

	// opcode prefixes, by prefix length
	localparam logic [1:0] OPC_ADD  = 2'b00;
	localparam logic [1:0] OPC_AND  = 2'b01;
	localparam logic [2:0] OPC_LODI = 3'b100;
	localparam logic [2:0] OPC_STOI = 3'b101;
	localparam logic [3:0] OPC_LOD  = 4'b1100;
	localparam logic [3:0] OPC_STO  = 4'b1101;
	localparam logic [3:0] OPC_BR   = 4'b1110;
	localparam logic [5:0] OPC_NOT  = 6'b111100;
	localparam logic [5:0] OPC_JMP  = 6'b111101;
	localparam logic [5:0] OPC_PRT  = 6'b111110;

	typedef enum logic [3:0] {
		OP_ADD, OP_AND, OP_LODI, OP_STOI, OP_LOD, OP_STO,
		OP_BR, OP_NOT, OP_JMP, OP_PRT, OP_RET
	} op_t;

	function automatic op_t decode_op(input logic [7:0] ins);
		op_t op;
		priority if (ins[7:6] == OPC_ADD)  op = OP_ADD;
		else if (ins[7:6] == OPC_AND)      op = OP_AND;
		else if (ins[7:5] == OPC_LODI)     op = OP_LODI;
		else if (ins[7:5] == OPC_STOI)     op = OP_STOI;
		else if (ins[7:4] == OPC_LOD)      op = OP_LOD;
		else if (ins[7:4] == OPC_STO)      op = OP_STO;
		else if (ins[7:4] == OPC_BR)       op = OP_BR;
		else if (ins[7:2] == OPC_NOT)      op = OP_NOT;
		else if (ins[7:2] == OPC_JMP)      op = OP_JMP;
		else if (ins[7:2] == OPC_PRT)      op = OP_PRT;
		else                               op = OP_RET;
		return op;
	endfunction

	// controller -> datapath
	typedef struct packed {
		logic do_wcode;
		logic do_wdata;
		logic do_start;
		logic do_halted;
		logic do_fault;
		logic do_fetch;
		logic do_exec;
		logic do_load;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic halted;
		logic pc_bad;
		logic ins_lod;
	} dp_sts_t;

endpackage

// ----- hdl/tecs_cmd_if.sv -----
// Command channel: valid/ready plus command, address and write value.
// No dependencies.
interface tecs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] address;
	logic [7:0] write_value;

	modport source (output valid, command, address, write_value, input ready);
	modport sink   (input valid, command, address, write_value, output ready);
endinterface

// ----- hdl/tecs_res_if.sv -----
// Result channel: valid/ready plus event, reported value and next pc.
// No dependencies.
interface tecs_res_if;
	logic              valid;
	logic              ready;
	logic        [2:0] event_res;
	logic signed [7:0] reported_value;
	logic        [7:0] next_pc;

	modport source (output valid, event_res, reported_value, next_pc, input ready);
	modport sink   (input valid, event_res, reported_value, next_pc, output ready);
endinterface

// ----- hdl/tecs_ctrl.sv -----
// Controller FSM of the tiny 8-bit core: handshakes and command sequencing.
// Depends on tecs_pkg.
module tecs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [1:0]          command,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tecs_pkg::dp_sts_t   sts,
	output tecs_pkg::ctl_cmd_t  cmd_o
);
	import tecs_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       res_load;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_comb begin
		cmd_o   = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_WCODE: cmd_o.do_wcode = 1'b1;
						CMD_WDATA: cmd_o.do_wdata = 1'b1;
						CMD_START: cmd_o.do_start = 1'b1;
						CMD_EXEC: begin
							priority if (sts.halted) cmd_o.do_halted = 1'b1;
							else if (sts.pc_bad)     cmd_o.do_fault  = 1'b1;
							else begin
								cmd_o.do_fetch = 1'b1;
								state_d        = S_EXEC;
							end
						end
						default: ;
					endcase
				end
			end
			S_EXEC: begin
				cmd_o.do_exec = 1'b1;
				state_d       = sts.ins_lod ? S_LOAD : S_IDLE;
			end
			S_LOAD: begin
				cmd_o.do_load = 1'b1;
				state_d       = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res_load = cmd_o.do_wcode | cmd_o.do_wdata | cmd_o.do_start | cmd_o.do_halted
		| cmd_o.do_fault | (cmd_o.do_exec & ~sts.ins_lod) | cmd_o.do_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_fetch_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.do_fetch |=> cmd_o.do_exec)
		else $error("fetch not followed by execute");
	a_load_after_lod: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> $past(cmd_o.do_exec && sts.ins_lod))
		else $error("load state without a lod instruction");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !res_load)
		else $error("pending result overwritten");
`endif
endmodule

// ----- hdl/tecs_dp.sv -----
// Datapath of the tiny 8-bit core: register file, pc, code and data stores, result register.
// Depends on tecs_pkg.
module tecs_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [8:0]              cfg_wdata,
	input  logic [7:0]              address,
	input  logic [7:0]              write_value,
	input  tecs_pkg::ctl_cmd_t      cmd_i,
	output tecs_pkg::dp_sts_t       sts,
	output logic [2:0]              event_res,
	output logic signed [7:0]       reported_value,
	output logic [7:0]              next_pc
);
	import tecs_pkg::*;

	logic [7:0]  regs_q [NUM_REGS];
	logic [7:0]  pc_q;
	logic        pc_out_q;
	logic        halted_q;
	logic [8:0]  len_q;
	logic [8:0]  limit;

	logic [7:0]  cmem [CODE_DEPTH];
	logic [7:0]  code_rd_q;
	logic [7:0]  dmem [DATA_DEPTH];
	logic [DATA_DEPTH-1:0] dvalid_q;
	logic [7:0]  data_rd_q;
	logic        data_ok_q;

	op_t         op;
	logic [7:0]  ins;
	logic        rf_we;
	logic [1:0]  rf_idx;
	logic [7:0]  rf_val;
	logic        dwe;
	logic [7:0]  dwaddr;
	logic [7:0]  dwdata;
	logic        drd_en;
	logic [9:0]  next10;
	logic [2:0]  ex_ev;
	logic [7:0]  ex_rep;
	logic        halt_set;
	logic        res_load;
	logic [2:0]  res_ev;
	logic [7:0]  res_val;
	logic [7:0]  res_npc;
	logic [7:0]  rm_a, rm_b;

	assign ins  = code_rd_q;
	assign op   = decode_op(ins);
	assign rm_a = regs_q[ins[3:2]];
	assign rm_b = regs_q[ins[1:0]];

	assign limit      = (len_q > CODE_LIMIT) ? CODE_LIMIT : len_q;
	assign sts.halted  = halted_q;
	assign sts.pc_bad  = pc_out_q || ({1'b0, pc_q} >= limit);
	assign sts.ins_lod = (op == OP_LOD);

	always_comb begin
		rf_we    = 1'b0;
		rf_idx   = ins[1:0];
		rf_val   = '0;
		dwe      = cmd_i.do_wdata;
		dwaddr   = address;
		dwdata   = write_value;
		drd_en   = 1'b0;
		next10   = {2'b00, pc_q} + 10'd1;
		ex_ev    = EV_DONE;
		ex_rep   = '0;
		halt_set = 1'b0;
		if (cmd_i.do_exec) begin
			unique case (op)
				OP_ADD: begin
					rf_we  = 1'b1;
					rf_idx = ins[5:4];
					rf_val = rm_a + rm_b;
				end
				OP_AND: begin
					rf_we  = 1'b1;
					rf_idx = ins[5:4];
					rf_val = rm_a & rm_b;
				end
				OP_LODI: begin
					rf_we  = 1'b1;
					rf_idx = ins[4:3];
					rf_val = {5'b0, ins[2:0]};
				end
				OP_STOI: begin
					dwe    = 1'b1;
					dwaddr = {5'b0, ins[2:0]};
					dwdata = regs_q[ins[4:3]];
				end
				OP_LOD: drd_en = 1'b1;
				OP_STO: begin
					dwe    = 1'b1;
					dwaddr = rm_b;
					dwdata = rm_a;
				end
				OP_BR: begin
					if (!rm_a[7]) next10 = {2'b00, pc_q} + 10'd1 + {{2{rm_b[7]}}, rm_b};
				end
				OP_NOT: begin
					rf_we  = 1'b1;
					rf_idx = ins[1:0];
					rf_val = ~rm_b;
				end
				OP_JMP: next10 = {2'b00, rm_b};
				OP_PRT: begin
					ex_ev  = EV_PRINT;
					ex_rep = rm_b;
				end
				OP_RET: begin
					ex_ev    = EV_RETURN;
					ex_rep   = rm_b;
					halt_set = 1'b1;
					next10   = {2'b00, pc_q};
				end
				default: ;
			endcase
		end
		if (cmd_i.do_load) begin
			rf_we  = 1'b1;
			rf_idx = ins[3:2];
			rf_val = data_ok_q ? data_rd_q : 8'd0;
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
			pc_q     <= '0;
			pc_out_q <= 1'b0;
			halted_q <= 1'b1;
			len_q    <= '0;
			dvalid_q <= '0;
		end else begin
			if (cfg_we) len_q <= cfg_wdata;
			if (cmd_i.do_start) begin
				for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
				pc_q     <= '0;
				pc_out_q <= 1'b0;
				halted_q <= 1'b0;
			end else begin
				if (rf_we) regs_q[rf_idx] <= rf_val;
				if (cmd_i.do_exec) begin
					pc_q <= next10[7:0];
					if (next10[9:8] != 2'b00) pc_out_q <= 1'b1;
				end
				if (cmd_i.do_fault || halt_set) halted_q <= 1'b1;
			end
			if (dwe) dvalid_q[dwaddr] <= 1'b1;
		end
	end

	// code store, registered read
	always_ff @(posedge clk) begin
		if (cmd_i.do_wcode && ({1'b0, address} < CODE_LIMIT))
			cmem[address[CODE_AW-1:0]] <= write_value;
		if (cmd_i.do_fetch) code_rd_q <= cmem[pc_q[CODE_AW-1:0]];
	end

	// data store, registered read; unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (dwe) dmem[dwaddr] <= dwdata;
		if (drd_en) begin
			data_rd_q <= dmem[rm_b];
			data_ok_q <= dvalid_q[rm_b];
		end
	end

	// result register
	always_comb begin
		res_load = 1'b1;
		res_ev   = EV_DONE;
		res_val  = '0;
		res_npc  = pc_q;
		priority if (cmd_i.do_start) res_npc = '0;
		else if (cmd_i.do_fault)     res_ev  = EV_FAULT;
		else if (cmd_i.do_halted)    res_ev  = EV_HALTED;
		else if (cmd_i.do_exec) begin
			res_load = (op != OP_LOD);
			res_ev   = ex_ev;
			res_val  = ex_rep;
			res_npc  = next10[7:0];
		end
		else if (cmd_i.do_wcode || cmd_i.do_wdata || cmd_i.do_load) res_load = 1'b1;
		else res_load = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			event_res      <= res_ev;
			reported_value <= res_val;
			next_pc        <= res_npc;
		end
	end

endmodule

// ----- hdl/tiny_eight_bit_core_step.sv -----
// Tiny 8-bit core, one command per beat. A write-code, write-data or start command
// is finished in the cycle it is accepted, and so is an execute that finds the core
// halted or its pc out of range. Any other execute command also passes the exec state:
// the code store has a registered read, so the instruction byte is fetched in the
// accept cycle and executed in the next. A register load through a pointer (lod)
// then adds the load state for the registered data store read. The next command is taken
// once the controller is back in idle and the result register is empty, or its
// result is taken by the sink in that same cycle. A result waits there until the
// sink takes it, and the input stalls meanwhile.
// Depends on tecs_pkg, tecs_cmd_if, tecs_res_if, tecs_ctrl and tecs_dp.
module tiny_eight_bit_core_step (
	input  logic        clk,
	input  logic        arst_n,
	tecs_cmd_if.sink    cmd,
	tecs_res_if.source  res,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata
);
	import tecs_pkg::*;

	// control and status between the FSM and the datapath
	ctl_cmd_t ctl_cmd;
	dp_sts_t  dp_sts;

	// FSM: owns both handshakes and the step sequence
	tecs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.command   (cmd.command),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.sts       (dp_sts),
		.cmd_o     (ctl_cmd)
	);

	// datapath: state, stores and the result beat's payload
	tecs_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.address        (cmd.address),
		.write_value    (cmd.write_value),
		.cmd_i          (ctl_cmd),
		.sts            (dp_sts),
		.event_res      (res.event_res),
		.reported_value (res.reported_value),
		.next_pc        (res.next_pc)
	);

endmodule

// ----- tb/sv/tiny_eight_bit_core_step_tb.sv -----
`timescale 1ns / 1ps
// Testbench for tiny_eight_bit_core_step: drives command beats, predicts each result
// with a shadow copy of the core, and checks results in order on the result channel.
// Depends on tecs_pkg, tecs_cmd_if, tecs_res_if and the core itself.
module tiny_eight_bit_core_step_tb;
	import tecs_pkg::*;

	// Instruction bytes are decoded by range: each class starts at its base byte.
	localparam logic [7:0] ENC_ADD  = 8'h00;
	localparam logic [7:0] ENC_AND  = 8'h40;
	localparam logic [7:0] ENC_LODI = 8'h80;
	localparam logic [7:0] ENC_STOI = 8'hA0;
	localparam logic [7:0] ENC_LOD  = 8'hC0;
	localparam logic [7:0] ENC_STO  = 8'hD0;
	localparam logic [7:0] ENC_BR   = 8'hE0;
	localparam logic [7:0] ENC_NOT  = 8'hF0;
	localparam logic [7:0] ENC_JMP  = 8'hF4;
	localparam logic [7:0] ENC_PRT  = 8'hF8;
	localparam logic [7:0] ENC_RET  = 8'hFC;

	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either channel
	localparam int SETTLE_CYCLES  = 6;     // idle wait before a length write
	localparam int STALL_CYCLES   = 300;   // long receiver hold-off
	localparam int PHASE_ITEMS    = 112;   // random commands per length setting
	localparam int REPORT_CAP     = 10;

	typedef struct packed {
		logic [2:0] ev;
		logic [7:0] val;
		logic [7:0] pc;
	} core_event_t;

	// Shadow core: tracks architectural state, queues the result each accepted
	// command should produce, and checks results in arrival order.
	class core_shadow;
		logic [7:0]  regs [NUM_REGS];
		logic [7:0]  dmem [DATA_DEPTH];
		logic [7:0]  imem [CODE_DEPTH];
		bit          imem_set [CODE_DEPTH];
		logic [7:0]  pc;
		bit          halted;
		bit          pc_out;
		logic [8:0]  prog_len;
		core_event_t due_results [$];
		int          mismatches;
		int          checked;
		int          ev_tally [5];

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			foreach (imem[i]) begin
				imem[i] = '0;
				imem_set[i] = 1'b0;
			end
			foreach (ev_tally[i]) ev_tally[i] = 0;
			pc = '0;
			halted = 1'b1;
			pc_out = 1'b0;
			prog_len = '0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pc_limit();
			return (int'(prog_len) < CODE_DEPTH) ? int'(prog_len) : CODE_DEPTH;
		endfunction

		// True when an execute now would fetch a code byte never written.
		function bit fetch_is_blank();
			return !halted && !pc_out && int'(pc) < pc_limit() && !imem_set[pc];
		endfunction

		function void apply_command(logic [1:0] op, logic [7:0] addr, logic [7:0] val);
			core_event_t r;
			logic [7:0]  ins;
			logic [1:0]  ra, rb, rc;
			int          nxt;
			r.ev  = EV_DONE;
			r.val = '0;
			case (op)
				CMD_WCODE: begin
					imem[addr] = val;
					imem_set[addr] = 1'b1;
				end
				CMD_WDATA: dmem[addr] = val;
				CMD_START: begin
					foreach (regs[i]) regs[i] = '0;
					pc = '0;
					halted = 1'b0;
					pc_out = 1'b0;
				end
				default: begin
					if (halted) begin
						r.ev = EV_HALTED;
					end else if (pc_out || int'(pc) >= pc_limit()) begin
						r.ev = EV_FAULT;
						halted = 1'b1;
					end else begin
						ins = imem[pc];
						nxt = int'(pc) + 1;
						if (ins < ENC_LODI) begin
							ra = ins[5:4];
							rb = ins[3:2];
							rc = ins[1:0];
							if (ins < ENC_AND) regs[ra] = regs[rb] + regs[rc];
							else regs[ra] = regs[rb] & regs[rc];
						end else if (ins < ENC_STOI) begin
							regs[ins[4:3]] = {5'd0, ins[2:0]};
						end else if (ins < ENC_LOD) begin
							dmem[{5'd0, ins[2:0]}] = regs[ins[4:3]];
						end else if (ins < ENC_NOT) begin
							ra = ins[3:2];
							rb = ins[1:0];
							if (ins < ENC_STO) regs[ra] = dmem[regs[rb]];
							else if (ins < ENC_BR) dmem[regs[rb]] = regs[ra];
							else if (!regs[ra][7]) nxt = nxt + int'($signed(regs[rb]));
						end else begin
							ra = ins[1:0];
							if (ins < ENC_JMP) begin
								regs[ra] = ~regs[ra];
							end else if (ins < ENC_PRT) begin
								nxt = int'(regs[ra]);
							end else if (ins < ENC_RET) begin
								r.ev  = EV_PRINT;
								r.val = regs[ra];
							end else begin
								r.ev  = EV_RETURN;
								r.val = regs[ra];
								halted = 1'b1;
								nxt = int'(pc);
							end
						end
						if (nxt < 0 || nxt > 255) pc_out = 1'b1;
						pc = nxt[7:0];
					end
				end
			endcase
			r.pc = pc;
			ev_tally[r.ev]++;
			due_results.push_back(r);
		endfunction

		function void compare_result(logic [2:0] ev, logic [7:0] val, logic [7:0] npc);
			core_event_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("[%0t] unexpected result: event %0d value %0d pc %0d",
						$realtime, ev, $signed(val), npc);
				return;
			end
			want = due_results.pop_front();
			checked++;
			if (want.ev !== ev || want.val !== val || want.pc !== npc) begin
				mismatches++;
				if (mismatches <= REPORT_CAP)
					$display("[%0t] result %0d mismatch: event %0d/%0d value %0d/%0d pc %0d/%0d (exp/got)",
						$realtime, checked, want.ev, ev, $signed(want.val), $signed(val),
						want.pc, npc);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	tecs_cmd_if cmd_bus ();
	tecs_res_if res_bus ();

	tiny_eight_bit_core_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_bus),
		.res       (res_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	core_shadow sb = new();

	int send_idle_pct;     // chance per cycle that the sender holds off
	int recv_idle_pct;     // chance per cycle that the receiver drops ready
	int stall_request;     // set by the main flow, consumed by the receiver process
	int items_sent;
	int lengths_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random instruction: pick a class evenly, then fill its operand bits at random.
	function automatic logic [7:0] random_instruction();
		logic [7:0] base, mask;
		case ($urandom_range(0, 10))
			0: begin base = ENC_ADD;  mask = 8'h3F; end
			1: begin base = ENC_AND;  mask = 8'h3F; end
			2: begin base = ENC_LODI; mask = 8'h1F; end
			3: begin base = ENC_STOI; mask = 8'h1F; end
			4: begin base = ENC_LOD;  mask = 8'h0F; end
			5: begin base = ENC_STO;  mask = 8'h0F; end
			6: begin base = ENC_BR;   mask = 8'h0F; end
			7: begin base = ENC_NOT;  mask = 8'h03; end
			8: begin base = ENC_JMP;  mask = 8'h03; end
			9: begin base = ENC_PRT;  mask = 8'h03; end
			default: begin base = ENC_RET; mask = 8'h03; end
		endcase
		return base | (8'($urandom) & mask);
	endfunction

	// One command beat. Gaps are random per cycle; once valid is up the payload
	// holds until the beat is taken. Called right after an edge, so valid is
	// assigned at most once per time step.
	task automatic send_command(input logic [1:0] op, input logic [7:0] addr,
			input logic [7:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_bus.valid       <= 1'b1;
		cmd_bus.command     <= op;
		cmd_bus.address     <= addr;
		cmd_bus.write_value <= val;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		sb.apply_command(op, addr, val);
		items_sent++;
	endtask

	// Execute one instruction; a blank fetch slot is filled with a random byte first
	// so the core never runs code that was never loaded.
	task automatic send_exec();
		if (sb.fetch_is_blank()) send_command(CMD_WCODE, sb.pc, random_instruction());
		send_command(CMD_EXEC, 8'($urandom), 8'($urandom));
	endtask

	// Any command with random fields.
	task automatic send_noise();
		logic [1:0] op;
		op = 2'($urandom_range(0, 3));
		if (op == CMD_EXEC) send_exec();
		else send_command(op, 8'($urandom), 8'($urandom));
	endtask

	// Stop offering, drain every outstanding result, let the core settle, then
	// write the length register while the core is idle.
	task automatic set_program_length(input logic [8:0] len);
		cmd_bus.valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.prog_len = len;
		lengths_used++;
	endtask

	// Typical use: load a short program at the bottom of code, maybe poke data,
	// start, and step until the core halts or the step budget runs out. A few
	// noise commands land in the middle of the run.
	task automatic run_program_burst();
		int span, n, steps, i;
		span = sb.pc_limit();
		if (span == 0 || span > 24) span = $urandom_range(4, 24);
		n = $urandom_range(1, span);
		for (i = 0; i < n; i++) send_command(CMD_WCODE, 8'(i), random_instruction());
		repeat ($urandom_range(0, 2)) send_command(CMD_WDATA, 8'($urandom), 8'($urandom));
		send_command(CMD_START, 8'($urandom), 8'($urandom));
		steps = $urandom_range(3, 30);
		while (steps > 0 && !sb.halted) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			else send_exec();
			steps--;
		end
		// now and then step a core that has already halted
		if ($urandom_range(0, 3) == 0) send_exec();
	endtask

	// Result side: check every taken beat, then pick ready for the next cycle.
	// A stall request holds ready low for a counted stretch.
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready)
				sb.compare_result(res_bus.event_res, res_bus.reported_value, res_bus.next_pc);
			if (stall_request > 0) begin
				hold_left = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: too long without a beat on either channel means the core hung.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no beat for %0d cycles, %0d results outstanding",
			$realtime, WATCHDOG_LIMIT, sb.due_results.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin : main_flow
		logic [8:0] phase_len [9];
		int         target, p;

		// length settings per phase: extremes mixed with ordinary values;
		// 511 and 300 clamp to the full code store, 256 is exactly full
		phase_len = '{9'd16, 9'd0, 9'd256, 9'd511, 9'd1, 9'd32, 9'd255, 9'd300, 9'd8};

		cmd_bus.valid       <= 1'b0;
		cmd_bus.command     <= CMD_WCODE;
		cmd_bus.address     <= '0;
		cmd_bus.write_value <= '0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		arst_n              <= 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 75;
		stall_request = 0;
		items_sent    = 0;
		lengths_used  = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// straight out of reset the core is halted; length is still zero, so
		// after start the first step faults and the next one sees a halted core
		send_command(CMD_EXEC, 8'hFF, 8'h00);
		send_command(CMD_START, 8'h00, 8'hFF);
		send_command(CMD_EXEC, 8'h00, 8'h00);
		send_command(CMD_EXEC, 8'hFF, 8'hFF);

		set_program_length(9'd16);
		// small program: lodi, add, not, stoi, sto, lod, prt, taken br, ret
		send_command(CMD_WCODE, 8'd0,  ENC_LODI | 8'b00_111);  // r0 = 7
		send_command(CMD_WCODE, 8'd1,  ENC_LODI | 8'b01_101);  // r1 = 5
		send_command(CMD_WCODE, 8'd2,  ENC_ADD  | 8'b10_00_01); // r2 = r0 + r1
		send_command(CMD_WCODE, 8'd3,  ENC_NOT  | 8'b11);      // r3 = ~r3 = -1
		send_command(CMD_WCODE, 8'd4,  ENC_STOI | 8'b10_111);  // data[7] = r2
		send_command(CMD_WCODE, 8'd5,  ENC_STO  | 8'b11_01);   // data[r1] = r3
		send_command(CMD_WCODE, 8'd6,  ENC_LOD  | 8'b00_01);   // r0 = data[r1]
		send_command(CMD_WCODE, 8'd7,  ENC_PRT  | 8'b00);      // print -1
		send_command(CMD_WCODE, 8'd8,  ENC_BR   | 8'b10_01);   // r2 >= 0: pc += 1 + r1
		send_command(CMD_WCODE, 8'd14, ENC_RET  | 8'b10);      // return 12, pc stays
		send_command(CMD_START, 8'h5A, 8'hA5);
		repeat (10) send_exec();

		// --- random ---
		// three idling modes, three length settings each; the no-idle mode
		// opens with a long receiver stall so the core backs up into its input
		target = items_sent;
		for (p = 0; p < 9; p++) begin
			case (p / 3)
				0: begin send_idle_pct = 30; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 30; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			set_program_length(phase_len[p]);
			if (p == 6) stall_request = STALL_CYCLES;
			target = target + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 5) == 0) send_noise();
				else run_program_burst();
			end
			// after each length setting the sender sits out until the core has drained
			cmd_bus.valid <= 1'b0;
			while (sb.due_results.size() != 0) @(posedge clk);
		end

		// --- drain ---
		repeat (20) @(posedge clk);

		$display("Covered %0d commands over %0d length settings, %0d results checked",
			items_sent, lengths_used, sb.checked);
		$display("Events seen: done %0d, print %0d, return %0d, fault %0d, halted %0d",
			sb.ev_tally[EV_DONE], sb.ev_tally[EV_PRINT], sb.ev_tally[EV_RETURN],
			sb.ev_tally[EV_FAULT], sb.ev_tally[EV_HALTED]);
		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches,
				sb.due_results.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
